>>> hdl/printf_format_feature_scanner_unit_macros.svh
// assertion macros for the printf format feature scanner
// used by the top level only, relies on clk_i and rst_ni in scope
`ifndef PRINTF_FORMAT_FEATURE_SCANNER_UNIT_MACROS_SVH
`define PRINTF_FORMAT_FEATURE_SCANNER_UNIT_MACROS_SVH

// same-cycle implication
`define PFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfs assertion failed");

// next-cycle implication
`define PFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfs assertion failed");

`endif

>>> hdl/pfs_pkg.sv
// shared types and constants for the printf format feature scanner
// no dependencies
package pfs_pkg;

  localparam int unsigned MaskW = 31;
  localparam int unsigned CharW = 8;

  localparam logic [MaskW-1:0] BitWidthPrec = 31'h4000_0000;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_PCT    = 3'd1,
    MODE_FLAGS  = 3'd2,
    MODE_DIGITS = 3'd3,
    MODE_CONV   = 3'd4,
    MODE_ENDED  = 3'd5
  } mode_e;

  typedef struct packed {
    logic is_zero;
    logic is_letter;
    logic is_digit;
    logic is_flag;
    logic is_dot;
    logic is_pct;
    logic is_ell;
  } char_class_t;

  typedef struct packed {
    logic [MaskW-1:0] plain_bit;
    logic [MaskW-1:0] long_bit;
  } conv_bits_t;

endpackage

>>> hdl/pfs_char_decode.sv
// character classifier and conversion letter table
// depends on pfs_pkg
module pfs_char_decode (
  input  logic [pfs_pkg::CharW-1:0] text_char_i,
  output pfs_pkg::char_class_t      cls_o,
  output pfs_pkg::conv_bits_t       conv_o
);

  always_comb begin
    cls_o.is_zero   = (text_char_i == 8'h00);
    cls_o.is_letter = ((text_char_i >= "a") && (text_char_i <= "z")) ||
                      ((text_char_i >= "A") && (text_char_i <= "Z"));
    cls_o.is_digit  = (text_char_i >= "0") && (text_char_i <= "9");
    cls_o.is_flag   = (text_char_i == "-") || (text_char_i == "0") ||
                      (text_char_i == "+") || (text_char_i == " ") ||
                      (text_char_i == "*") || (text_char_i == ".");
    cls_o.is_dot    = (text_char_i == ".");
    cls_o.is_pct    = (text_char_i == "%");
    cls_o.is_ell    = (text_char_i == "l");
  end

  always_comb begin
    conv_o.plain_bit = '0;
    conv_o.long_bit  = '0;
    case (text_char_i)
      "d": begin conv_o.plain_bit = 31'h0000_0001; conv_o.long_bit = 31'h0000_1000; end
      "u": begin conv_o.plain_bit = 31'h0000_0002; conv_o.long_bit = 31'h0000_2000; end
      "x": begin conv_o.plain_bit = 31'h0000_0004; conv_o.long_bit = 31'h0000_4000; end
      "X": begin conv_o.plain_bit = 31'h0000_0008; conv_o.long_bit = 31'h0000_8000; end
      "o": begin conv_o.plain_bit = 31'h0000_0010; conv_o.long_bit = 31'h0001_0000; end
      "n": begin conv_o.plain_bit = 31'h0000_0020; conv_o.long_bit = 31'h0002_0000; end
      "i": begin conv_o.plain_bit = 31'h0000_0040; conv_o.long_bit = 31'h0004_0000; end
      "p": begin conv_o.plain_bit = 31'h0000_0080; conv_o.long_bit = 31'h0008_0000; end
      "B": begin conv_o.plain_bit = 31'h0000_0100; conv_o.long_bit = 31'h0010_0000; end
      "s": begin conv_o.plain_bit = 31'h0000_0200; end
      "c": begin conv_o.plain_bit = 31'h0000_0400; end
      "a": begin conv_o.plain_bit = 31'h0040_0000; end
      "A": begin conv_o.plain_bit = 31'h0080_0000; end
      "e": begin conv_o.plain_bit = 31'h0100_0000; conv_o.long_bit = 31'h0100_0000; end
      "E": begin conv_o.plain_bit = 31'h0200_0000; conv_o.long_bit = 31'h0200_0000; end
      "f": begin conv_o.plain_bit = 31'h0400_0000; conv_o.long_bit = 31'h0400_0000; end
      "F": begin conv_o.plain_bit = 31'h0800_0000; conv_o.long_bit = 31'h0800_0000; end
      "g": begin conv_o.plain_bit = 31'h1000_0000; conv_o.long_bit = 31'h1000_0000; end
      "G": begin conv_o.plain_bit = 31'h2000_0000; conv_o.long_bit = 31'h2000_0000; end
      default: begin
        conv_o.plain_bit = '0;
        conv_o.long_bit  = '0;
      end
    endcase
  end

endmodule

>>> hdl/pfs_scan_core.sv
// scan state registers and per-character next-state logic
// depends on pfs_pkg and pfs_char_decode
module pfs_scan_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_en_i,
  input  logic [pfs_pkg::CharW-1:0] text_char_i,
  input  logic                      is_last_i,
  output logic [pfs_pkg::MaskW-1:0] result_mask_o
);

  pfs_pkg::mode_e            mode_q, mode_d;
  logic                      long_q, long_d;
  logic [pfs_pkg::MaskW-1:0] mask_q, mask_d;
  pfs_pkg::char_class_t      cls;
  pfs_pkg::conv_bits_t       conv;
  logic                      len_pos;
  pfs_pkg::mode_e            after_conv;

  pfs_char_decode u_decode (
    .text_char_i (text_char_i),
    .cls_o       (cls),
    .conv_o      (conv)
  );

  assign after_conv = cls.is_pct ? pfs_pkg::MODE_PCT : pfs_pkg::MODE_IDLE;

  always_comb begin
    mode_d  = mode_q;
    long_d  = long_q;
    mask_d  = mask_q;
    len_pos = 1'b0;
    if (mode_q != pfs_pkg::MODE_ENDED) begin
      if (cls.is_zero) begin
        mode_d = pfs_pkg::MODE_ENDED;
      end else begin
        case (mode_q)
          pfs_pkg::MODE_PCT: begin
            if (cls.is_flag) begin
              mask_d = mask_q | pfs_pkg::BitWidthPrec;
              mode_d = pfs_pkg::MODE_FLAGS;
            end else if (cls.is_digit) begin
              mask_d = mask_q | pfs_pkg::BitWidthPrec;
              mode_d = pfs_pkg::MODE_DIGITS;
            end else begin
              len_pos = 1'b1;
            end
          end
          pfs_pkg::MODE_FLAGS: begin
            len_pos = cls.is_letter;
          end
          pfs_pkg::MODE_DIGITS: begin
            len_pos = !(cls.is_digit || cls.is_dot);
          end
          pfs_pkg::MODE_CONV: begin
            mask_d = mask_q | (long_q ? conv.long_bit : conv.plain_bit);
            long_d = 1'b0;
            mode_d = after_conv;
          end
          default: begin
            mode_d = after_conv;
          end
        endcase
        if (len_pos) begin
          if (cls.is_ell) begin
            long_d = 1'b1;
            mode_d = pfs_pkg::MODE_CONV;
          end else begin
            mask_d = mask_q | conv.plain_bit;
            long_d = 1'b0;
            mode_d = after_conv;
          end
        end
      end
    end
  end

  assign result_mask_o = mask_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pfs_pkg::MODE_IDLE;
      long_q <= 1'b0;
      mask_q <= '0;
    end else if (step_en_i) begin
      if (is_last_i) begin
        mode_q <= pfs_pkg::MODE_IDLE;
        long_q <= 1'b0;
        mask_q <= '0;
      end else begin
        mode_q <= mode_d;
        long_q <= long_d;
        mask_q <= mask_d;
      end
    end
  end

endmodule

>>> hdl/printf_format_feature_scanner_unit.sv
// top level of the printf format feature scanner: input register, scan core, result register
// depends on pfs_pkg, pfs_scan_core and the assertion macro header
//
// channel   dir  tdata                     tuser  tlast
// s_axis    in   [7:0] text_char           -      is_last
// m_axis    out  [30:0] feature_mask       -      -
//
// one character per cycle unless a last word waits on a stalled result word; input register, then result register
// the scan state lives in the core and is updated by the word leaving the input register
// a last word waits in the input register only while a result word is stalled
// reset clears the scan state and all valid flags, no clearing pass
`include "printf_format_feature_scanner_unit_macros.svh"

module printf_format_feature_scanner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [30:0] feature_mask, [31] zero
);

  logic                      in_valid_q;
  logic [pfs_pkg::CharW-1:0] in_char_q;
  logic                      in_last_q;
  logic                      out_valid_q;
  logic [pfs_pkg::MaskW-1:0] out_mask_q;
  logic [pfs_pkg::MaskW-1:0] result_mask;
  logic                      advance;

  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  pfs_scan_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (advance),
    .text_char_i   (in_char_q),
    .is_last_i     (in_last_q),
    .result_mask_o (result_mask)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_mask_q <= result_mask;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_mask_q};

  `PFS_ASSERT_IMP(a_stall_only_on_last, !s_axis_tready, in_valid_q && in_last_q && out_valid_q)
  `PFS_ASSERT_NXT(a_last_gives_result, advance && in_last_q, m_axis_tvalid)
  `PFS_ASSERT_NXT(a_no_result_without_last, !m_axis_tvalid && !(advance && in_last_q), !m_axis_tvalid)

endmodule
